>>> src/pshs_pkg.sv
// Shared constants, types and helpers of the pair-sum hash search block.
`timescale 1ns / 1ps
`default_nettype none

package pshs_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 1024;
  localparam int NUM_CELLS   = 4;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CELL_W      = $clog2(NUM_CELLS);
  localparam int ROWS        = TABLE_SLOTS / NUM_CELLS;
  localparam int ROW_W       = $clog2(ROWS);

  // Field widths
  localparam int KEY_W = 32;
  localparam int IDX_W = 10;

  // List tag kept with every slot; a slot is occupied when its tag matches
  localparam int EP_W = 8;

  typedef enum logic [1:0] {
    STAT_FOUND    = 2'd0,
    STAT_NONE     = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LAUNCH,
    ST_FIND,
    ST_PUT,
    ST_EMIT
  } ctrl_state_t;

  // One stored slot
  typedef struct packed {
    logic [EP_W-1:0]   ep;
    logic [SLOT_W-1:0] pos;
    logic [KEY_W-1:0]  key;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  // Probe walking along the ring of cells
  typedef struct packed {
    logic              valid;
    logic              find;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] pos;
    logic [ROW_W-1:0]  row;
  } tok_t;

  // Probe start: token plus the cell that holds its home slot
  typedef struct packed {
    tok_t              tok;
    logic [CELL_W-1:0] bank;
  } inj_t;

  // Probe end report
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [SLOT_W-1:0] pos;
  } done_t;

  // Table sweep command, one row of every cell per cycle
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
  } clr_t;

  // Home slot: magnitude of the key modulo the slot count
  function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [SLOT_W-1:0] lo;
    lo = key[SLOT_W-1:0];
    return key[KEY_W-1] ? (~lo + 1'b1) : lo;
  endfunction

endpackage

`default_nettype wire

>>> src/pshs_ifs.sv
// Valid/ready channel interfaces: input items, results and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface pshs_in_if import pshs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] item_value;
  logic             first_of_list;
  logic             last_of_list;

  modport source (output valid, item_value, first_of_list, last_of_list, input ready);
  modport sink (input valid, item_value, first_of_list, last_of_list, output ready);
endinterface

interface pshs_out_if import pshs_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [IDX_W-1:0] earlier_index;
  logic [IDX_W-1:0] later_index;

  modport source (output valid, status, earlier_index, later_index, input ready);
  modport sink (input valid, status, earlier_index, later_index, output ready);
endinterface

interface pshs_cfg_if import pshs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> src/pair_sum_hash_search.sv
// Top level: list sequencer, target register, result register and cell ring.
// Next item: taken only once the current one is stored, found, ignored or has overflowed;
//   each extra slot probed and each output stall delays it.
// Result: registered out of the emit state after a list-ending probe or an overflow transfer.
// Reset: synchronous, then a sweep of every table row, no transfer taken. A new list at tag
//   wrap (list 256, then every 255th) reruns the sweep, delaying its first item.
`timescale 1ns / 1ps
`default_nettype none

module pair_sum_hash_search import pshs_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  pshs_in_if.sink   in_ch,
  pshs_out_if.source out_ch,
  pshs_cfg_if.sink  cfg_ch
);

  localparam logic [EP_W-1:0] EP_MAX = '1;

  ctrl_state_t       st_r, st_nxt;
  logic [ROW_W-1:0]  row_r;
  logic              pend_r;
  logic [EP_W-1:0]   ep_r;
  logic              done_r;
  logic [SLOT_W-1:0] items_r;
  logic [KEY_W-1:0]  tgt_r;
  logic [KEY_W-1:0]  val_r;
  logic              last_r;
  logic [SLOT_W-1:0] here_r;
  inj_t              inj_r, inj_nxt;
  status_t           res_st_r, res_st_nxt;
  logic [IDX_W-1:0]  res_e_r, res_e_nxt;
  logic [IDX_W-1:0]  res_l_r, res_l_nxt;
  logic              out_valid_r;
  status_t           out_st_r;
  logic [IDX_W-1:0]  out_e_r;
  logic [IDX_W-1:0]  out_l_r;

  logic              in_ready;
  logic              in_fire;
  logic              first;
  logic              act;
  logic              need_sweep;
  logic [SLOT_W-1:0] here_in;
  logic              ovf_in;
  logic [KEY_W-1:0]  src_val;
  logic [KEY_W-1:0]  comp;
  logic [SLOT_W-1:0] comp_home;
  logic [SLOT_W-1:0] val_home;
  logic              go_find;
  logic              go_ovf;
  logic              find_hit;
  logic              find_miss;
  logic              put_end;
  logic              emit;
  logic              sweep_end;
  clr_t              clr;
  done_t             done;

  // Handshake decode
  assign in_ready     = (st_r == ST_IDLE);
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;

  assign first      = in_ch.first_of_list;
  assign act        = first || !done_r;
  assign need_sweep = first && (ep_r == EP_MAX);
  assign here_in    = first ? '0 : items_r;
  assign ovf_in     = (here_in >= SLOT_W'(TABLE_SLOTS - 1));

  // Complement and home slots
  assign src_val   = (st_r == ST_LAUNCH) ? val_r : in_ch.item_value;
  assign comp      = tgt_r - src_val;
  assign comp_home = home_slot(comp);
  assign val_home  = home_slot(val_r);

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: begin
        if (row_r == ROW_W'(ROWS - 1)) st_nxt = pend_r ? ST_LAUNCH : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          priority if (need_sweep) st_nxt = ST_CLEAR;
          else if (!act) st_nxt = ST_IDLE;
          else if (ovf_in) st_nxt = ST_EMIT;
          else st_nxt = ST_FIND;
        end
      end
      ST_LAUNCH: st_nxt = ST_FIND;
      ST_FIND: begin
        if (done.valid) st_nxt = done.hit ? ST_EMIT : ST_PUT;
      end
      ST_PUT: begin
        if (done.valid) st_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: probe starts, sweep command, pending result
  always_comb begin
    go_find   = (in_fire && act && !need_sweep && !ovf_in) || (st_r == ST_LAUNCH);
    go_ovf    = in_fire && act && !need_sweep && ovf_in;
    find_hit  = (st_r == ST_FIND) && done.valid && done.hit;
    find_miss = (st_r == ST_FIND) && done.valid && !done.hit;
    put_end   = (st_r == ST_PUT) && done.valid;
    emit      = (st_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
    sweep_end = (st_r == ST_CLEAR) && (row_r == ROW_W'(ROWS - 1));
    clr.valid = (st_r == ST_CLEAR);
    clr.row   = row_r;

    inj_nxt = '0;
    if (go_find) begin
      inj_nxt.tok.valid = 1'b1;
      inj_nxt.tok.find  = 1'b1;
      inj_nxt.tok.key   = comp;
      inj_nxt.tok.pos   = (st_r == ST_LAUNCH) ? here_r : here_in;
      inj_nxt.tok.row   = comp_home[SLOT_W-1:CELL_W];
      inj_nxt.bank      = comp_home[CELL_W-1:0];
    end else if (find_miss) begin
      inj_nxt.tok.valid = 1'b1;
      inj_nxt.tok.find  = 1'b0;
      inj_nxt.tok.key   = val_r;
      inj_nxt.tok.pos   = here_r;
      inj_nxt.tok.row   = val_home[SLOT_W-1:CELL_W];
      inj_nxt.bank      = val_home[CELL_W-1:0];
    end

    res_st_nxt = res_st_r;
    res_e_nxt  = res_e_r;
    res_l_nxt  = res_l_r;
    priority if (go_ovf) begin
      res_st_nxt = STAT_OVERFLOW;
      res_e_nxt  = '0;
      res_l_nxt  = '0;
    end else if (find_hit) begin
      res_st_nxt = STAT_FOUND;
      res_e_nxt  = IDX_W'(done.pos);
      res_l_nxt  = IDX_W'(here_r);
    end else if (put_end) begin
      res_st_nxt = STAT_NONE;
      res_e_nxt  = '0;
      res_l_nxt  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      row_r       <= '0;
      pend_r      <= 1'b0;
      ep_r        <= '0;
      done_r      <= 1'b1;
      items_r     <= '0;
      tgt_r       <= '0;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r            <= st_nxt;
      inj_r           <= inj_nxt;
      if (cfg_ch.valid) tgt_r <= cfg_ch.data;
      if (st_r == ST_CLEAR) row_r <= row_r + 1'b1;

      // List tag: new list takes the next tag, a sweep restarts the tags
      if (in_fire && need_sweep) begin
        pend_r <= 1'b1;
      end else if (sweep_end) begin
        pend_r <= 1'b0;
      end
      if (sweep_end) begin
        ep_r <= pend_r ? EP_W'(1) : '0;
      end else if (in_fire && first && !need_sweep) begin
        ep_r <= ep_r + 1'b1;
      end

      // List progress
      if (in_fire && first) begin
        items_r <= '0;
        done_r  <= 1'b0;
      end else if (go_ovf || find_hit) begin
        done_r <= 1'b1;
      end else if (put_end) begin
        items_r <= here_r + 1'b1;
        if (last_r) done_r <= 1'b1;
      end

      // Result register
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      val_r  <= in_ch.item_value;
      last_r <= in_ch.last_of_list;
      here_r <= here_in;
    end
    res_st_r       <= res_st_nxt;
    res_e_r        <= res_e_nxt;
    res_l_r        <= res_l_nxt;
    if (emit) begin
      out_st_r <= res_st_r;
      out_e_r  <= res_e_r;
      out_l_r  <= res_l_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.earlier_index = out_e_r;
  assign out_ch.later_index   = out_l_r;

  pshs_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .inj   (inj_r),
    .ep    (ep_r),
    .clr   (clr),
    .done  (done)
  );

  // A probe report only arrives while a walk is awaited
  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |-> ((st_r == ST_FIND) || (st_r == ST_PUT)))
    else $error("probe report outside a walk");

  // At most one probe is started at a time
  a_single_start: assert property (@(posedge clk) disable iff (!rst_n)
    inj_r.tok.valid |=> !inj_r.tok.valid)
    else $error("probe started twice in a row");

  // A failed lookup is followed by the insert walk
  a_put_follows: assert property (@(posedge clk) disable iff (!rst_n)
    find_miss |=> (inj_r.tok.valid && !inj_r.tok.find))
    else $error("insert walk missing after failed lookup");

  // An open list never runs under the tag that marks swept slots
  a_tag_live: assert property (@(posedge clk) disable iff (!rst_n)
    (!done_r && (st_r != ST_CLEAR) && !pend_r) |-> (ep_r != '0))
    else $error("open list uses the empty tag");

endmodule

`default_nettype wire

>>> src/pshs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pshs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/pshs_cell.sv
// One ring cell: a bank of table slots and one probe stage over it.
`timescale 1ns / 1ps
`default_nettype none

module pshs_cell import pshs_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tok_t            tok_in,
  input  wire logic [EP_W-1:0] ep,
  input  wire clr_t            clr,
  output tok_t                 tok_out,
  output done_t                done
);

  tok_t             hold_r;
  logic [ENT_W-1:0] rdata;
  entry_t           ent;
  logic             occ;
  logic             put_we;
  logic             we;
  logic [ROW_W-1:0] waddr;
  logic [ENT_W-1:0] wdata;

  // Probe stage: token waits here while its slot is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else begin
      hold_r <= tok_in;
    end
  end

  // Slot check: empty ends both walks, key match ends a lookup
  always_comb begin
    ent     = entry_t'(rdata);
    occ     = (ent.ep == ep);
    tok_out = hold_r;
    done    = '0;
    put_we  = 1'b0;
    if (hold_r.valid) begin
      if (!occ) begin
        tok_out.valid = 1'b0;
        done.valid    = 1'b1;
        put_we        = !hold_r.find;
      end else if (hold_r.find && (ent.key == hold_r.key)) begin
        tok_out.valid = 1'b0;
        done.valid    = 1'b1;
        done.hit      = 1'b1;
        done.pos      = ent.pos;
      end
    end
  end

  // Write port: sweep has priority, never overlaps a probe
  always_comb begin
    we    = clr.valid || put_we;
    waddr = clr.valid ? clr.row : hold_r.row;
    wdata = clr.valid ? ENT_W'(0) : ENT_W'({ep, hold_r.pos, hold_r.key});
  end

  pshs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ROWS)
  ) u_bank (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (tok_in.row),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

>>> src/pshs_ring.sv
// Ring of cells: probe start routing, neighbor links and report merge.
`timescale 1ns / 1ps
`default_nettype none

module pshs_ring import pshs_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire inj_t            inj,
  input  wire logic [EP_W-1:0] ep,
  input  wire clr_t            clr,
  output done_t                done
);

  tok_t  tok_in  [NUM_CELLS];
  tok_t  tok_out [NUM_CELLS];
  done_t rep     [NUM_CELLS];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    tok_t lnk;

    // Link from the left neighbor; leaving the last cell moves to the next row
    if (k == 0) begin : g_wrap
      always_comb begin
        lnk     = tok_out[NUM_CELLS-1];
        lnk.row = tok_out[NUM_CELLS-1].row + 1'b1;
      end
    end else begin : g_link
      assign lnk = tok_out[k-1];
    end

    // A new probe enters at the cell holding its home slot
    assign tok_in[k] = (inj.tok.valid && (inj.bank == CELL_W'(k))) ? inj.tok : lnk;

    pshs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok_in[k]),
      .ep      (ep),
      .clr     (clr),
      .tok_out (tok_out[k]),
      .done    (rep[k])
    );
  end

  // Only one probe is in flight, so the reports merge by OR
  always_comb begin
    done = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      done = done | rep[k];
    end
  end

endmodule

`default_nettype wire
